FILE: sv/ggd_pkg.sv
// ----------------------------------------------------------------------------
// ggd_pkg: shared types and constants for grid goal descent
// Item structs, sequencer states, status codes, register indexes and the
// rounding helpers used around the shared multiplier.
// ----------------------------------------------------------------------------
package ggd_pkg;

    // grid geometry and limits
    localparam int GRID_SIDE  = 256;
    localparam int STEP_LIMIT = 10;
    localparam int COORD_W    = $clog2(GRID_SIDE);
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int CNT_W      = $clog2(STEP_LIMIT + 2);

    // fixed field widths
    localparam int DIM_W    = 9;
    localparam int THR_W    = 7;
    localparam int RES_W    = 16;
    localparam int COST_W   = 8;
    localparam int METER_W  = 16;
    localparam int POS_W    = 18;
    localparam int MUL_A_W  = 18;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int OFS_W    = 2;
    localparam int SUM_W    = 4;
    localparam int SCAN_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COST_W-1:0] BLOCK_COST = 8'sd98;
    localparam logic [SCAN_W-1:0] SCAN_LAST = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_CELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_METER = 3'd4;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_FOUND   = 2'd0,
        STATUS_BLOCKED = 2'd1,
        STATUS_NO_FREE = 2'd2
    } ggd_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_RND_Y,
        ST_CHECK,
        ST_CENTER,
        ST_TEST,
        ST_SCAN,
        ST_MOVE,
        ST_OMUL_X,
        ST_OMUL_Y,
        ST_ORND_Y,
        ST_DONE
    } ggd_state_t;

    typedef struct packed {
        logic                      action;
        logic [15:0]               cell_address;
        logic signed [COST_W-1:0]  cell_value;
        logic signed [15:0]        goal_x;
        logic signed [15:0]        goal_y;
    } ggd_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
    } ggd_rsp_t;

    // column offset of neighbor k, column-major over the 3x3 window
    function automatic logic signed [OFS_W-1:0] nbr_dx(input logic [SCAN_W-1:0] k);
        logic signed [OFS_W-1:0] d;
        d = 2'sd0;
        unique case (k)
            4'd0, 4'd1, 4'd2: d = -2'sd1;
            4'd3, 4'd4, 4'd5: d = 2'sd0;
            4'd6, 4'd7, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    // row offset of neighbor k
    function automatic logic signed [OFS_W-1:0] nbr_dy(input logic [SCAN_W-1:0] k);
        logic signed [OFS_W-1:0] d;
        d = 2'sd0;
        unique case (k)
            4'd0, 4'd3, 4'd6: d = -2'sd1;
            4'd1, 4'd4, 4'd7: d = 2'sd0;
            4'd2, 4'd5, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    // meters times cells-per-meter over 2^16, rounded half away from zero
    function automatic logic signed [POS_W-1:0] cell_round(
        input logic signed [PROD_W-1:0] p
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sum;
        logic [16:0]       q;
        mag = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
        sum = mag + PROD_W'(32768);
        q   = sum[32:16];
        return p[PROD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // cell magnitude times meters-per-cell over 2^8, rounded and saturated
    function automatic logic [RES_W-1:0] meter_round(
        input logic [PROD_W-1:0] p,
        input logic              neg
    );
        logic [24:0] sum;
        logic [16:0] q;
        logic [RES_W-1:0] r;
        sum = p[24:0] + 25'd128;
        q   = sum[24:8];
        if (neg) begin
            if (q > 17'd32768) begin
                q = 17'd32768;
            end
            r = RES_W'(17'd0 - q);
        end else begin
            if (q > 17'd32767) begin
                q = 17'd32767;
            end
            r = q[RES_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/ggd_ram.sv
// ----------------------------------------------------------------------------
// ggd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ggd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/grid_goal_descent_from_obstacle_top.sv
// ----------------------------------------------------------------------------
// grid_goal_descent_from_obstacle_top: goal descent on an occupancy grid
// Stores a signed 8-bit cost grid, converts a goal in meters to a cell,
// checks it, walks it downhill away from the costliest neighbor and
// returns it in meters.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | carries
//  --------+--------------------------------+----------------------------------
//  req     | req_valid, req_stall, req      | cell write or goal query item
//  rsp     | rsp_valid, rsp_stall, rsp      | status and moved goal, per query
//  cfg     | cfg_wr_en, cfg_index, cfg_data | register write, no read-back
//
//  a query converts the goal to a cell and reads the center cell, then runs
//  descent steps (one grid read per neighbor through the single read port)
//  and converts the result back to meters; the step limit is 10.
//  one multiplier serves both conversions; req_stall is high for the whole query.
//  a finished result waits in the output register while the next item enters.
//  reset restores the register defaults; the grid is not cleared.
//
module grid_goal_descent_from_obstacle_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  ggd_pkg::ggd_req_t               req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output ggd_pkg::ggd_rsp_t               rsp,
    input  logic                            cfg_wr_en,
    input  logic [ggd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data
);

    import ggd_pkg::*;

    ggd_state_t state_reg, state_next;

    // configuration
    logic [DIM_W-1:0]   map_width_reg, map_height_reg;
    logic [THR_W-1:0]   cost_threshold_reg;
    logic [METER_W-1:0] meters_per_cell_reg, cells_per_meter_reg;

    // query datapath
    logic signed [15:0]         goal_x_reg, goal_y_reg;
    logic signed [POS_W-1:0]    cx_reg, cy_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [SCAN_W-1:0]          scan_k_reg;
    logic                       pipe_vld_reg;
    logic signed [OFS_W-1:0]    pipe_dx_reg, pipe_dy_reg;
    logic signed [COST_W-1:0]   best_reg;
    logic signed [SUM_W-1:0]    fx_reg, fy_reg;
    ggd_status_t                status_reg;
    logic [RES_W-1:0]           new_x_reg, new_y_reg;
    ggd_rsp_t                   rsp_reg;
    logic                       rsp_valid_reg;

    // control from the output decoder
    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;

    logic                       req_accept;
    logic                       wr_en;
    logic                       rsp_load;
    logic [COST_W-1:0]          rd_data;
    logic signed [COST_W-1:0]   cost;

    // effective grid size and derived values
    logic [DIM_W-1:0]           w, h;
    logic signed [POS_W-1:0]    qw, qh, ws, hs;
    logic [DIM_W+1:0]           w3, h3;
    logic signed [POS_W+1:0]    cx4, cy4;
    logic                       region_fail;
    logic signed [COST_W-1:0]   thr_s;
    logic                       cost_blocked, cost_high;

    // neighbor scan and move
    logic signed [OFS_W-1:0]    k_dx, k_dy;
    logic signed [POS_W-1:0]    nx, ny;
    logic                       nbr_in;
    logic signed [POS_W-1:0]    mx, my;
    logic signed [POS_W-1:0]    sgn_x, sgn_y;
    logic                       move_fail;

    // output conversion
    logic signed [POS_W-1:0]    dx_out, dy_out;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign wr_en      = req_accept && (req.action == ACT_WRITE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign rsp_load   = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign cost       = $signed(rd_data);

    // grid store
    ggd_ram #(
        .WIDTH (COST_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (req.cell_address),
        .wr_data (req.cell_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // grid size clamp and central-half test
    always_comb
    begin
        w  = (map_width_reg  > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : map_width_reg;
        h  = (map_height_reg > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : map_height_reg;
        qw = $signed({{(POS_W-DIM_W+2){1'b0}}, w[DIM_W-1:2]});
        qh = $signed({{(POS_W-DIM_W+2){1'b0}}, h[DIM_W-1:2]});
        ws = $signed({{(POS_W-DIM_W){1'b0}}, w});
        hs = $signed({{(POS_W-DIM_W){1'b0}}, h});
        w3 = {2'b00, w} + {1'b0, w, 1'b0};
        h3 = {2'b00, h} + {1'b0, h, 1'b0};
        cx4 = {cx_reg, 2'b00};
        cy4 = {cy_reg, 2'b00};
        region_fail = (cx4 < $signed({{(POS_W-DIM_W+2){1'b0}}, w}))
                   || (cx4 >= $signed({{(POS_W-DIM_W){1'b0}}, w3}))
                   || (cy4 < $signed({{(POS_W-DIM_W+2){1'b0}}, h}))
                   || (cy4 >= $signed({{(POS_W-DIM_W){1'b0}}, h3}));
        thr_s        = $signed({1'b0, cost_threshold_reg});
        cost_blocked = (count_reg == '0) && (cost > BLOCK_COST);
        cost_high    = (cost >= thr_s);
    end

    // neighbor address, move and output offsets
    always_comb
    begin
        k_dx   = nbr_dx(scan_k_reg);
        k_dy   = nbr_dy(scan_k_reg);
        nx     = cx_reg + POS_W'(k_dx);
        ny     = cy_reg + POS_W'(k_dy);
        nbr_in = (nx >= 0) && (nx < ws) && (ny >= 0) && (ny < hs);
        sgn_x  = (fx_reg > 0) ? POS_W'(1) : ((fx_reg < 0) ? -POS_W'(1) : '0);
        sgn_y  = (fy_reg > 0) ? POS_W'(1) : ((fy_reg < 0) ? -POS_W'(1) : '0);
        mx     = cx_reg - sgn_x;
        my     = cy_reg - sgn_y;
        move_fail = (count_reg > CNT_W'(STEP_LIMIT))
                 || (mx < 0) || (my < 0) || (mx >= ws) || (my >= hs);
        dx_out = cx_reg - qw;
        dy_out = cy_reg - qh;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (req.action == ACT_QUERY))
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_RND_Y;
            ST_RND_Y:  state_next = ST_CHECK;
            ST_CHECK:  state_next = region_fail ? ST_DONE : ST_CENTER;
            ST_CENTER: state_next = ST_TEST;
            ST_TEST:
            begin
                priority if (cost_blocked)
                begin
                    state_next = ST_DONE;
                end
                else if (cost_high)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_OMUL_X;
                end
            end
            ST_SCAN:
            begin
                if (scan_k_reg == SCAN_LAST)
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:   state_next = move_fail ? ST_DONE : ST_CENTER;
            ST_OMUL_X: state_next = ST_OMUL_Y;
            ST_OMUL_Y: state_next = ST_ORND_Y;
            ST_ORND_Y: state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // multiplier operands and grid reads
    always_comb
    begin
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        rd_en   = 1'b0;
        rd_addr = {cy_reg[COORD_W-1:0], cx_reg[COORD_W-1:0]};
        unique case (state_reg)
            ST_MUL_X:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(goal_x_reg);
                mul_b  = $signed({1'b0, cells_per_meter_reg});
            end
            ST_MUL_Y:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(goal_y_reg);
                mul_b  = $signed({1'b0, cells_per_meter_reg});
            end
            ST_CENTER:
            begin
                rd_en = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en   = (scan_k_reg != SCAN_LAST);
                rd_addr = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
            end
            ST_OMUL_X:
            begin
                mul_en = 1'b1;
                mul_a  = dx_out[POS_W-1] ? -dx_out : dx_out;
                mul_b  = $signed({1'b0, meters_per_cell_reg});
            end
            ST_OMUL_Y:
            begin
                mul_en = 1'b1;
                mul_a  = dy_out[POS_W-1] ? -dy_out : dy_out;
                mul_b  = $signed({1'b0, meters_per_cell_reg});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            map_width_reg       <= DIM_W'(256);
            map_height_reg      <= DIM_W'(256);
            cost_threshold_reg  <= THR_W'(50);
            meters_per_cell_reg <= METER_W'(1311);
            cells_per_meter_reg <= METER_W'(12800);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_MAP_WIDTH:       map_width_reg       <= cfg_data[DIM_W-1:0];
                    CFG_MAP_HEIGHT:      map_height_reg      <= cfg_data[DIM_W-1:0];
                    CFG_COST_THRESHOLD:  cost_threshold_reg  <= cfg_data[THR_W-1:0];
                    CFG_METERS_PER_CELL: meters_per_cell_reg <= cfg_data;
                    CFG_CELLS_PER_METER: cells_per_meter_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (req_accept)
        begin
            count_reg <= '0;
        end
        else if ((state_reg == ST_TEST) && !cost_blocked && cost_high)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // shared multiplier
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.status <= status_reg;
            rsp_reg.new_x  <= (status_reg == STATUS_FOUND) ? $signed(new_x_reg) : '0;
            rsp_reg.new_y  <= (status_reg == STATUS_FOUND) ? $signed(new_y_reg) : '0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                goal_x_reg <= req.goal_x;
                goal_y_reg <= req.goal_y;
                status_reg <= STATUS_FOUND;
            end
            ST_MUL_Y:
            begin
                cx_reg <= cell_round(prod_reg) + qw;
            end
            ST_RND_Y:
            begin
                cy_reg <= cell_round(prod_reg) + qh;
            end
            ST_CHECK:
            begin
                if (region_fail)
                begin
                    status_reg <= STATUS_BLOCKED;
                end
            end
            ST_TEST:
            begin
                if (cost_blocked)
                begin
                    status_reg <= STATUS_BLOCKED;
                end
                scan_k_reg   <= '0;
                pipe_vld_reg <= 1'b0;
                best_reg     <= '0;
                fx_reg       <= '0;
                fy_reg       <= '0;
            end
            ST_SCAN:
            begin
                // issue neighbor k, compare the one read last cycle
                pipe_vld_reg <= (scan_k_reg != SCAN_LAST) && nbr_in;
                pipe_dx_reg  <= k_dx;
                pipe_dy_reg  <= k_dy;
                if (scan_k_reg != SCAN_LAST)
                begin
                    scan_k_reg <= scan_k_reg + SCAN_W'(1);
                end
                if (pipe_vld_reg)
                begin
                    priority if (cost > best_reg)
                    begin
                        best_reg <= cost;
                        fx_reg   <= SUM_W'(pipe_dx_reg);
                        fy_reg   <= SUM_W'(pipe_dy_reg);
                    end
                    else if (cost == best_reg)
                    begin
                        fx_reg <= fx_reg + SUM_W'(pipe_dx_reg);
                        fy_reg <= fy_reg + SUM_W'(pipe_dy_reg);
                    end
                    else
                    begin
                        best_reg <= best_reg;
                    end
                end
            end
            ST_MOVE:
            begin
                cx_reg <= mx;
                cy_reg <= my;
                if (move_fail)
                begin
                    status_reg <= STATUS_NO_FREE;
                end
            end
            ST_OMUL_Y:
            begin
                new_x_reg <= meter_round($unsigned(prod_reg), dx_out[POS_W-1]);
            end
            ST_ORND_Y:
            begin
                new_y_reg <= meter_round($unsigned(prod_reg), dy_out[POS_W-1]);
            end
            default:
            begin
                status_reg <= status_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    // the step counter stops one past the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STEP_LIMIT + 1))
        else $error("step counter ran past the limit");

    // the goal stays inside the grid while its neighbors are scanned
    a_scan_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cx_reg >= 0) && (cx_reg < ws) && (cy_reg >= 0) && (cy_reg < hs))
        else $error("scan started from a cell outside the grid");

    // a result appears only after the sequencer finished a query
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    // failed queries return zero coordinates
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != STATUS_FOUND))
            |-> (rsp_reg.new_x == 16'sd0) && (rsp_reg.new_y == 16'sd0))
        else $error("failed query carries nonzero coordinates");
`endif

endmodule
